### rtl/core/nnsb_pkg.sv
// ----------------------------------------------------------------------------
// nnsb_pkg
// Shared types and constants of the nearest-neighbor scaled blitter.
// ----------------------------------------------------------------------------
package nnsb_pkg;

   localparam int STORE_ADDR_W = 14;
   localparam int STORE_DEPTH  = 1 << STORE_ADDR_W;
   localparam int TEXEL_W      = 32;
   localparam int COLOR_W      = 31;
   localparam int DIM_W        = 8;
   localparam int TGT_W        = 11;
   localparam int POS_W        = 10;
   localparam int IMG_W        = 12;
   localparam int OUT_W        = 13;
   localparam int NUM_W        = POS_W + DIM_W;
   localparam int DIV_LAT      = NUM_W + 1;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_DRAW = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_TEX_WIDTH     = 3'd0,
      REG_TEX_HEIGHT    = 3'd1,
      REG_TARGET_WIDTH  = 3'd2,
      REG_TARGET_HEIGHT = 3'd3,
      REG_DEST_X        = 3'd4,
      REG_DEST_Y        = 3'd5,
      REG_IMG_WIDTH     = 3'd6,
      REG_IMG_HEIGHT    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] tex_width;
      logic [DIM_W-1:0] tex_height;
      logic [TGT_W-1:0] target_width;
      logic [TGT_W-1:0] target_height;
      logic [IMG_W-1:0] dest_x;
      logic [IMG_W-1:0] dest_y;
      logic [IMG_W-1:0] img_width;
      logic [IMG_W-1:0] img_height;
   } cfg_type;

endpackage

### rtl/core/nnsb_if.sv
// ----------------------------------------------------------------------------
// nnsb_if
// Valid/ready channels of the blitter: request and response.
// ----------------------------------------------------------------------------
interface nnsb_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [9:0]         col;
   logic [9:0]         row;
   logic [13:0]        texel_addr;
   logic signed [31:0] texel_value;

   modport source (output valid, operation, col, row, texel_addr, texel_value,
                   input ready);
   modport sink (input valid, operation, col, row, texel_addr, texel_value,
                 output ready);
endinterface

interface nnsb_rsp_if;
   logic               valid;
   logic               ready;
   logic               write_enable;
   logic signed [12:0] out_x;
   logic signed [12:0] out_y;
   logic [30:0]        color;

   modport source (output valid, write_enable, out_x, out_y, color, input ready);
   modport sink (input valid, write_enable, out_x, out_y, color, output ready);
endinterface

### rtl/core/nnsb_csr.sv
// ----------------------------------------------------------------------------
// nnsb_csr
// Configuration registers behind a bus port with setup and access cycles.
// ----------------------------------------------------------------------------
module nnsb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [nnsb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [nnsb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [nnsb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output nnsb_pkg::cfg_type              cfg
);
   import nnsb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (index)
            REG_TEX_WIDTH:     cfg_in.tex_width     = pwdata[DIM_W-1:0];
            REG_TEX_HEIGHT:    cfg_in.tex_height    = pwdata[DIM_W-1:0];
            REG_TARGET_WIDTH:  cfg_in.target_width  = pwdata[TGT_W-1:0];
            REG_TARGET_HEIGHT: cfg_in.target_height = pwdata[TGT_W-1:0];
            REG_DEST_X:        cfg_in.dest_x        = pwdata[IMG_W-1:0];
            REG_DEST_Y:        cfg_in.dest_y        = pwdata[IMG_W-1:0];
            REG_IMG_WIDTH:     cfg_in.img_width     = pwdata[IMG_W-1:0];
            REG_IMG_HEIGHT:    cfg_in.img_height    = pwdata[IMG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TEX_WIDTH:     prdata = CSR_DATA_W'(cfg_ff.tex_width);
         REG_TEX_HEIGHT:    prdata = CSR_DATA_W'(cfg_ff.tex_height);
         REG_TARGET_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.target_width);
         REG_TARGET_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.target_height);
         REG_DEST_X:        prdata = CSR_DATA_W'(cfg_ff.dest_x);
         REG_DEST_Y:        prdata = CSR_DATA_W'(cfg_ff.dest_y);
         REG_IMG_WIDTH:     prdata = CSR_DATA_W'(cfg_ff.img_width);
         REG_IMG_HEIGHT:    prdata = CSR_DATA_W'(cfg_ff.img_height);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_width     <= DIM_W'(128);
         cfg_ff.tex_height    <= DIM_W'(128);
         cfg_ff.target_width  <= TGT_W'(128);
         cfg_ff.target_height <= TGT_W'(128);
         cfg_ff.dest_x        <= '0;
         cfg_ff.dest_y        <= '0;
         cfg_ff.img_width     <= IMG_W'(640);
         cfg_ff.img_height    <= IMG_W'(480);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/nnsb_divider.sv
// ----------------------------------------------------------------------------
// nnsb_divider
// Restoring divider, one quotient bit per stage, clamped to a limit.
// ----------------------------------------------------------------------------
module nnsb_divider (
   input  logic                         clock,
   input  logic                         en,
   input  logic [nnsb_pkg::NUM_W-1:0]   num,
   input  logic [nnsb_pkg::TGT_W-1:0]   den,
   input  logic [nnsb_pkg::DIM_W-1:0]   limit,
   output logic [nnsb_pkg::DIM_W-1:0]   coord
);
   import nnsb_pkg::*;

   logic [TGT_W-1:0] rem_ff  [NUM_W];
   logic [NUM_W-1:0] quo_ff  [NUM_W];
   logic [NUM_W-1:0] num_ff  [NUM_W];
   logic [TGT_W-1:0] rem_in  [NUM_W];
   logic [NUM_W-1:0] quo_in  [NUM_W];
   logic [NUM_W-1:0] num_in  [NUM_W];
   logic [TGT_W-1:0] den_eff;
   logic [DIM_W-1:0] coord_ff;
   logic [DIM_W-1:0] coord_in;

   assign den_eff = (den == '0) ? TGT_W'(1) : den;

   always_comb begin
      logic [TGT_W-1:0] rem_p;
      logic [NUM_W-1:0] quo_p;
      logic [NUM_W-1:0] num_p;
      logic [TGT_W:0]   trial;
      logic             ge;
      for (int k = 0; k < NUM_W; k++) begin
         rem_p = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k - 1];
         quo_p = (k == 0) ? '0 : quo_ff[(k == 0) ? 0 : k - 1];
         num_p = (k == 0) ? num : num_ff[(k == 0) ? 0 : k - 1];
         trial = {rem_p, num_p[NUM_W-1]};
         ge    = trial >= {1'b0, den_eff};
         rem_in[k] = ge ? TGT_W'(trial - {1'b0, den_eff}) : trial[TGT_W-1:0];
         quo_in[k] = {quo_p[NUM_W-2:0], ge};
         num_in[k] = {num_p[NUM_W-2:0], 1'b0};
      end
   end

   always_comb begin
      if (quo_ff[NUM_W-1] >= NUM_W'(limit)) begin
         coord_in = (limit == '0) ? '0 : limit - DIM_W'(1);
      end else begin
         coord_in = quo_ff[NUM_W-1][DIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_W; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            num_ff[k] <= num_in[k];
         end
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

### rtl/core/nnsb_texel_store.sv
// ----------------------------------------------------------------------------
// nnsb_texel_store
// Texture memory: one write or one registered read per transfer.
// ----------------------------------------------------------------------------
module nnsb_texel_store (
   input  logic                              clock,
   input  logic                              en,
   input  logic                              wr,
   input  logic [nnsb_pkg::STORE_ADDR_W-1:0] addr,
   input  logic [nnsb_pkg::TEXEL_W-1:0]      wdata,
   output logic [nnsb_pkg::TEXEL_W-1:0]      rdata
);
   import nnsb_pkg::*;

   logic [TEXEL_W-1:0] mem [STORE_DEPTH];
   logic [TEXEL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && wr) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/nearest_neighbor_scaled_blit_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaled_blit_unit
// Nearest-neighbor sprite blitter: texel loads and scaled pixel draws.
//
//   channel | direction | handshake         | payload
//   req     | in        | valid/ready       | operation col row texel_addr texel_value
//   rsp     | out       | valid/ready       | write_enable out_x out_y color
//   csr     | in        | psel/penable      | paddr pwdata prdata
//
// One transfer per cycle unless the result stalls; the stages are product, 18
// divider stages and a clamp, texel address, memory read, result register.
// The texture memory has one port shared by loads and draws in one stage.
// Synchronous reset clears valid bits and presets CSRs; data and memory are kept.
// A stalled result freezes the whole pipe.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaled_blit_unit (
   input  logic                           clock,
   input  logic                           reset,
   nnsb_req_if.sink                       req,
   nnsb_rsp_if.source                     rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [nnsb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nnsb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nnsb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import nnsb_pkg::*;

   cfg_type cfg;
   logic    en;

   nnsb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // product stage
   logic                    s1_valid_ff;
   op_type                  s1_op_ff;
   logic [POS_W-1:0]        s1_col_ff, s1_row_ff;
   logic [STORE_ADDR_W-1:0] s1_addr_ff;
   logic [TEXEL_W-1:0]      s1_value_ff;
   logic [NUM_W-1:0]        s1_numx_ff, s1_numy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff    <= op_type'(req.operation);
         s1_col_ff   <= req.col;
         s1_row_ff   <= req.row;
         s1_addr_ff  <= req.texel_addr;
         s1_value_ff <= req.texel_value;
         s1_numx_ff  <= NUM_W'(req.col) * NUM_W'(cfg.tex_width);
         s1_numy_ff  <= NUM_W'(req.row) * NUM_W'(cfg.tex_height);
      end
   end

   // divider stages
   logic [DIM_W-1:0] sx, sy;

   nnsb_divider u_div_x (
      .clock (clock),
      .en    (en),
      .num   (s1_numx_ff),
      .den   (cfg.target_width),
      .limit (cfg.tex_width),
      .coord (sx)
   );

   nnsb_divider u_div_y (
      .clock (clock),
      .en    (en),
      .num   (s1_numy_ff),
      .den   (cfg.target_height),
      .limit (cfg.tex_height),
      .coord (sy)
   );

   logic                    car_valid_ff [DIV_LAT];
   op_type                  car_op_ff    [DIV_LAT];
   logic [POS_W-1:0]        car_col_ff   [DIV_LAT];
   logic [POS_W-1:0]        car_row_ff   [DIV_LAT];
   logic [STORE_ADDR_W-1:0] car_addr_ff  [DIV_LAT];
   logic [TEXEL_W-1:0]      car_value_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            car_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         car_valid_ff[0] <= s1_valid_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            car_valid_ff[k] <= car_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         car_op_ff[0]    <= s1_op_ff;
         car_col_ff[0]   <= s1_col_ff;
         car_row_ff[0]   <= s1_row_ff;
         car_addr_ff[0]  <= s1_addr_ff;
         car_value_ff[0] <= s1_value_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            car_op_ff[k]    <= car_op_ff[k-1];
            car_col_ff[k]   <= car_col_ff[k-1];
            car_row_ff[k]   <= car_row_ff[k-1];
            car_addr_ff[k]  <= car_addr_ff[k-1];
            car_value_ff[k] <= car_value_ff[k-1];
         end
      end
   end

   // texel address stage
   logic                    a_valid_ff;
   op_type                  a_op_ff;
   logic [POS_W-1:0]        a_col_ff, a_row_ff;
   logic [STORE_ADDR_W-1:0] a_addr_ff, a_addr_in;
   logic [TEXEL_W-1:0]      a_value_ff;
   logic [2*DIM_W:0]        lin_addr;

   assign lin_addr = (2*DIM_W+1)'(sy) * (2*DIM_W+1)'(cfg.tex_width)
                   + (2*DIM_W+1)'(sx);
   assign a_addr_in = (car_op_ff[DIV_LAT-1] == OP_LOAD) ? car_addr_ff[DIV_LAT-1]
                                                        : lin_addr[STORE_ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= car_valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff    <= car_op_ff[DIV_LAT-1];
         a_col_ff   <= car_col_ff[DIV_LAT-1];
         a_row_ff   <= car_row_ff[DIV_LAT-1];
         a_addr_ff  <= a_addr_in;
         a_value_ff <= car_value_ff[DIV_LAT-1];
      end
   end

   // memory stage
   logic               m_valid_ff;
   op_type             m_op_ff;
   logic [POS_W-1:0]   m_col_ff, m_row_ff;
   logic [TEXEL_W-1:0] texel;

   nnsb_texel_store u_store (
      .clock (clock),
      .en    (en),
      .wr    (a_valid_ff && (a_op_ff == OP_LOAD)),
      .addr  (a_addr_ff),
      .wdata (a_value_ff),
      .rdata (texel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_op_ff  <= a_op_ff;
         m_col_ff <= a_col_ff;
         m_row_ff <= a_row_ff;
      end
   end

   // result stage
   logic [OUT_W-1:0]   x_pos, y_pos;
   logic               in_image, positive, draw;
   logic               we_ff, we_in;
   logic [OUT_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   assign x_pos    = {cfg.dest_x[IMG_W-1], cfg.dest_x} + OUT_W'(m_col_ff);
   assign y_pos    = {cfg.dest_y[IMG_W-1], cfg.dest_y} + OUT_W'(m_row_ff);
   assign in_image = !x_pos[OUT_W-1] && !y_pos[OUT_W-1]
                  && (x_pos[IMG_W-1:0] < cfg.img_width)
                  && (y_pos[IMG_W-1:0] < cfg.img_height);
   assign positive = (texel != '0) && !texel[TEXEL_W-1];
   assign draw     = (m_op_ff == OP_DRAW);
   assign we_in    = draw && in_image && positive;
   assign x_in     = draw ? x_pos : '0;
   assign y_in     = draw ? y_pos : '0;
   assign color_in = we_in ? texel[COLOR_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         we_ff    <= we_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         color_ff <= color_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.write_enable = we_ff;
   assign rsp.out_x        = x_ff;
   assign rsp.out_y        = y_ff;
   assign rsp.color        = color_ff;

`ifndef ASSERT_OFF
   a_quiet_color : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.write_enable |-> rsp.color == '0)
      else $error("color set without write");

   a_write_color : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.write_enable |-> rsp.color != '0)
      else $error("write with zero color");

   a_write_inside : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.write_enable |-> !rsp.out_x[OUT_W-1] && !rsp.out_y[OUT_W-1])
      else $error("write outside image");
`endif

endmodule
